@@ rtl/cfcr_pkg.sv @@
// cfcr_pkg: shared types, codes and the CRC-16 byte update for the
// command frame receiver. No dependencies.
`default_nettype none

package cfcr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [7:0]  LenFloor = 8'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST  = 3'd0,
    CFG_HEADER_SECOND = 3'd1,
    CFG_MIN_LENGTH    = 3'd2,
    CFG_CRC_SEED      = 3'd3,
    CFG_ACCEPT_ZERO   = 3'd4,
    CFG_COMMAND_COUNT = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ERROR   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BODY    = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    VERD_COMMAND = 2'd0,
    VERD_ACK     = 2'd1,
    VERD_UNKNOWN = 2'd2,
    VERD_CRC_ERR = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  min_length;
    logic [15:0] crc_seed;
    logic        accept_zero_crc;
    logic [7:0]  command_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] body_byte;
    logic [1:0] verdict;
    logic [6:0] sequence_res;
    logic [7:0] command_class;
    logic [7:0] body_length;
  } res_t;

  // reflected CRC-16, one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cfcr_if.sv @@
// cfcr_if: valid/ready channel interfaces for received items and results.
// No dependencies.
`default_nettype none

interface cfcr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface cfcr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] body_byte;
  logic [1:0] verdict;
  logic [6:0] sequence_res;
  logic [7:0] command_class;
  logic [7:0] body_length;

  modport source (output valid, output result_kind, output body_byte, output verdict,
                  output sequence_res, output command_class, output body_length,
                  input ready);
  modport sink   (input valid, input result_kind, input body_byte, input verdict,
                  input sequence_res, input command_class, input body_length,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/cfcr_cfg_regs.sv @@
// cfcr_cfg_regs: configuration register bank, write-only.
// Depends on cfcr_pkg.
`default_nettype none

module cfcr_cfg_regs (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [cfcr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  [cfcr_pkg::CfgDataW-1:0]       cfg_data_i,
  output cfcr_pkg::cfg_t                      cfg_o
);

  cfcr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfcr_pkg::CFG_HEADER_FIRST:  cfg_d.header_first    = cfg_data_i[7:0];
        cfcr_pkg::CFG_HEADER_SECOND: cfg_d.header_second   = cfg_data_i[7:0];
        cfcr_pkg::CFG_MIN_LENGTH:    cfg_d.min_length      = cfg_data_i[7:0];
        cfcr_pkg::CFG_CRC_SEED:      cfg_d.crc_seed        = cfg_data_i[15:0];
        cfcr_pkg::CFG_ACCEPT_ZERO:   cfg_d.accept_zero_crc = cfg_data_i[0];
        cfcr_pkg::CFG_COMMAND_COUNT: cfg_d.command_count   = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first    <= 8'hAA;
      cfg_q.header_second   <= 8'h55;
      cfg_q.min_length      <= 8'd4;
      cfg_q.crc_seed        <= 16'hFFFF;
      cfg_q.accept_zero_crc <= 1'b1;
      cfg_q.command_count   <= 8'd16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/cfcr_parser.sv @@
// cfcr_parser: frame state machine, CRC register and result formation for
// one item per step. Depends on cfcr_pkg.
`default_nettype none

module cfcr_parser (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire cfcr_pkg::cfg_t cfg_i,
  input  wire             step_i,
  input  wire             operation_i,
  input  wire  [7:0]      rx_byte_i,
  output logic            res_vld_o,
  output cfcr_pkg::res_t  res_o
);

  cfcr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  last_q, last_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  logic [7:0]  min_len;
  logic [8:0]  pos;
  logic        in_crc_span;
  logic [15:0] rx_crc;
  logic        crc_ok;

  assign min_len     = (cfg_i.min_length < cfcr_pkg::LenFloor) ? cfcr_pkg::LenFloor
                                                               : cfg_i.min_length;
  assign pos         = {1'b0, cnt_q} + 9'd2;
  assign in_crc_span = pos < {1'b0, len_q};
  assign rx_crc      = {rx_byte_i, crc_lo_q};
  assign crc_ok      = (rx_crc == crc_q) || (cfg_i.accept_zero_crc && (rx_crc == 16'h0000));

  always_comb begin
    phase_d   = phase_q;
    last_d    = last_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    first_d   = first_q;
    class_d   = class_q;
    crc_lo_d  = crc_lo_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (step_i) begin
      if (operation_i == cfcr_pkg::OP_TIMEOUT) begin
        phase_d           = cfcr_pkg::PH_IDLE;
        res_vld_o         = 1'b1;
        res_o.result_kind = cfcr_pkg::KIND_TIMEOUT;
      end else begin
        unique case (phase_q)
          cfcr_pkg::PH_IDLE: begin
            if (rx_byte_i == cfg_i.header_second && last_q == cfg_i.header_first) begin
              phase_d = cfcr_pkg::PH_LEN;
            end else begin
              last_d = rx_byte_i;
            end
          end
          cfcr_pkg::PH_LEN: begin
            if (rx_byte_i >= min_len) begin
              len_d   = rx_byte_i;
              cnt_d   = 8'd0;
              crc_d   = cfg_i.crc_seed;
              phase_d = cfcr_pkg::PH_PAYLOAD;
            end else begin
              phase_d = cfcr_pkg::PH_ERROR;
            end
          end
          cfcr_pkg::PH_PAYLOAD: begin
            cnt_d = cnt_q + 8'd1;
            if (in_crc_span) begin
              crc_d = cfcr_pkg::crc_byte(crc_q, rx_byte_i);
            end
            res_o.sequence_res  = first_q[6:0];
            res_o.command_class = class_q;
            res_o.body_length   = len_q - 8'd4;
            if (cnt_q == 8'd0) begin
              first_d = rx_byte_i;
              res_o   = '0;
            end else if (cnt_q == 8'd1) begin
              class_d = rx_byte_i;
              res_o   = '0;
            end else if (in_crc_span) begin
              res_vld_o         = 1'b1;
              res_o.result_kind = cfcr_pkg::KIND_BODY;
              res_o.body_byte   = rx_byte_i;
            end else if (pos == {1'b0, len_q}) begin
              crc_lo_d = rx_byte_i;
              res_o    = '0;
            end else begin
              phase_d           = cfcr_pkg::PH_IDLE;
              res_vld_o         = 1'b1;
              res_o.result_kind = cfcr_pkg::KIND_VERDICT;
              if (!crc_ok) begin
                res_o.verdict = cfcr_pkg::VERD_CRC_ERR;
              end else if (first_q[7]) begin
                res_o.verdict = cfcr_pkg::VERD_ACK;
              end else if (class_q < cfg_i.command_count) begin
                res_o.verdict = cfcr_pkg::VERD_COMMAND;
              end else begin
                res_o.verdict = cfcr_pkg::VERD_UNKNOWN;
              end
            end
          end
          cfcr_pkg::PH_ERROR: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cfcr_pkg::PH_IDLE;
      last_q   <= 8'h00;
      len_q    <= 8'h00;
      cnt_q    <= 8'h00;
      crc_q    <= 16'hFFFF;
      first_q  <= 8'h00;
      class_q  <= 8'h00;
      crc_lo_q <= 8'h00;
    end else begin
      phase_q  <= phase_d;
      last_q   <= last_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      first_q  <= first_d;
      class_q  <= class_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/crc16_command_frame_receiver.sv @@
// crc16_command_frame_receiver: top level, input register, result register.
// Depends on cfcr_pkg, cfcr_if, cfcr_cfg_regs, cfcr_parser.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    operation, rx_byte
//   out_ch    out   valid/ready    result_kind .. body_length
//   cfg       in    cfg_we_i       cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while out_ch is not stalled; an item's result
// is offered on out_ch after the input register, then the result register.
// A held item steps the parser whenever the result register is empty or being
// drained, so out_ch backpressure stalls the input register, then in_ch.ready.
// rst_ni clears both stages and all frame state; no clearing pass.
`default_nettype none

module crc16_command_frame_receiver (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [cfcr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [cfcr_pkg::CfgDataW-1:0]    cfg_data_i,
  cfcr_in_if.sink                          in_ch,
  cfcr_out_if.source                       out_ch
);

  cfcr_pkg::cfg_t cfg;
  cfcr_pkg::res_t res;
  logic           res_vld;

  logic           in_vld_q;
  logic           op_q;
  logic [7:0]     byte_q;
  logic           out_vld_q, out_vld_d;
  cfcr_pkg::res_t out_q;
  logic           advance;
  logic           step;

  assign advance     = !out_vld_q || out_ch.ready;
  assign step        = in_vld_q && advance;
  assign in_ch.ready = !in_vld_q || advance;

  cfcr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cfcr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .operation_i (op_q),
    .rx_byte_i   (byte_q),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      op_q   <= in_ch.operation;
      byte_q <= in_ch.rx_byte;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = step && res_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_vld) begin
      out_q <= res;
    end
  end

  assign out_ch.valid         = out_vld_q;
  assign out_ch.result_kind   = out_q.result_kind;
  assign out_ch.body_byte     = out_q.body_byte;
  assign out_ch.verdict       = out_q.verdict;
  assign out_ch.sequence_res  = out_q.sequence_res;
  assign out_ch.command_class = out_q.command_class;
  assign out_ch.body_length   = out_q.body_length;

endmodule

`default_nettype wire

@@ dv/crc16_command_frame_receiver_test.sv @@
// Testbench for crc16_command_frame_receiver: streams sync-framed byte traffic
// with timeouts, predicts every result with its own scoreboard model and
// checks each one. Depends on cfcr_pkg, cfcr_if and the block itself.

module crc16_command_frame_receiver_test;
  import cfcr_pkg::*;

  localparam int HalfPeriod   = 10;
  localparam int ResetCycles  = 5;
  localparam int SettleCycles = 6;
  localparam int DrainLimit   = 20000;
  localparam int HoldCycles   = 200;
  localparam int NumSlots     = 8;
  localparam int SlotItems    = 50;
  localparam int NoCut        = 256;
  localparam int WatchdogTime = 10_000_000;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareB = 3'd7;

  typedef enum {CRC_GOOD, CRC_ZERO, CRC_BAD} crc_mode_e;

  class frame_scoreboard;
    cfg_t        cfg;
    phase_e      phase;
    logic [7:0]  last_byte, frame_len, byte_idx, seq_byte, class_byte, crc_lo;
    logic [15:0] crc_acc;
    res_t        expected_q[$];
    int          mismatches, n_checked, n_body, n_timeout;
    int          n_verdict[4];

    function new();
      cfg = '{header_first: 8'hAA, header_second: 8'h55, min_length: 8'd4,
              crc_seed: 16'hFFFF, accept_zero_crc: 1'b1, command_count: 8'd16};
      phase      = PH_IDLE;
      last_byte  = '0;
      frame_len  = '0;
      byte_idx   = '0;
      seq_byte   = '0;
      class_byte = '0;
      crc_lo     = '0;
      crc_acc    = cfg.crc_seed;
      mismatches = 0;
      n_checked  = 0;
      n_body     = 0;
      n_timeout  = 0;
      n_verdict  = '{0, 0, 0, 0};
    endfunction

    // reflected CRC-16, fed one bit at a time lsb first
    static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CrcPoly;
        end
      end
      return c;
    endfunction

    function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_HEADER_FIRST:  cfg.header_first    = data[7:0];
        CFG_HEADER_SECOND: cfg.header_second   = data[7:0];
        CFG_MIN_LENGTH:    cfg.min_length      = data[7:0];
        CFG_CRC_SEED:      cfg.crc_seed        = data;
        CFG_ACCEPT_ZERO:   cfg.accept_zero_crc = data[0];
        CFG_COMMAND_COUNT: cfg.command_count   = data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // returns 0 when the item is dropped without effect (error phase)
    function bit note_input(op_e op, logic [7:0] b);
      res_t        r;
      logic [7:0]  idx, floor;
      logic [15:0] rx_crc;
      bit          in_crc, crc_ok;
      r = '0;
      if (op == OP_TIMEOUT) begin
        phase = PH_IDLE;
        r.result_kind = KIND_TIMEOUT;
        expected_q.push_back(r);
        n_timeout++;
        return 1'b1;
      end
      case (phase)
        PH_IDLE: begin
          if (b == cfg.header_second && last_byte == cfg.header_first) begin
            phase = PH_LEN;
          end else begin
            last_byte = b;
          end
        end
        PH_LEN: begin
          floor = (cfg.min_length < LenFloor) ? LenFloor : cfg.min_length;
          if (b >= floor) begin
            frame_len = b;
            byte_idx  = '0;
            crc_acc   = cfg.crc_seed;
            phase     = PH_PAYLOAD;
          end else begin
            phase = PH_ERROR;
          end
        end
        PH_PAYLOAD: begin
          idx      = byte_idx;
          byte_idx = byte_idx + 8'd1;
          in_crc   = (9'(idx) + 9'd2) < 9'(frame_len);
          if (in_crc) begin
            crc_acc = crc_update(crc_acc, b);
          end
          r.sequence_res  = seq_byte[6:0];
          r.command_class = class_byte;
          r.body_length   = frame_len - 8'd4;
          if (idx == 8'd0) begin
            seq_byte = b;
          end else if (idx == 8'd1) begin
            class_byte = b;
          end else if (in_crc) begin
            r.result_kind = KIND_BODY;
            r.body_byte   = b;
            expected_q.push_back(r);
            n_body++;
          end else if ((9'(idx) + 9'd2) == 9'(frame_len)) begin
            crc_lo = b;
          end else begin
            rx_crc = {b, crc_lo};
            crc_ok = (rx_crc == crc_acc) || (cfg.accept_zero_crc && rx_crc == 16'h0000);
            if (!crc_ok) begin
              r.verdict = VERD_CRC_ERR;
            end else if (seq_byte[7]) begin
              r.verdict = VERD_ACK;
            end else if (class_byte < cfg.command_count) begin
              r.verdict = VERD_COMMAND;
            end else begin
              r.verdict = VERD_UNKNOWN;
            end
            r.result_kind = KIND_VERDICT;
            phase = PH_IDLE;
            expected_q.push_back(r);
            n_verdict[r.verdict]++;
          end
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task field_eq(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got 0x%0h, want 0x%0h", n_checked, name, got, want));
      end
    endtask

    task check_result(res_t got);
      res_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d of kind %0d arrived with nothing expected",
                         n_checked, got.result_kind));
        return;
      end
      want = expected_q.pop_front();
      field_eq("result_kind", got.result_kind, want.result_kind);
      field_eq("body_byte", got.body_byte, want.body_byte);
      field_eq("verdict", got.verdict, want.verdict);
      field_eq("sequence_res", got.sequence_res, want.sequence_res);
      field_eq("command_class", got.command_class, want.command_class);
      field_eq("body_length", got.body_length, want.body_length);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int                  sender_idle_pct = 0;
  int                  recv_stall_pct = 0;
  bit                  hold_req = 1'b0;
  int                  counted_items = 0;
  int                  n_settings = 0;
  frame_scoreboard     sb = new();

  cfcr_in_if  in_ch ();
  cfcr_out_if out_ch ();

  crc16_command_frame_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #HalfPeriod clk_i = ~clk_i;

  initial begin
    #(WatchdogTime);
    $display("FAIL");
    $finish;
  end

  // result side: check on handshake, then pick ready for the next edge
  initial begin : receiver
    res_t got;
    int   hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.result_kind   = out_ch.result_kind;
        got.body_byte     = out_ch.body_byte;
        got.verdict       = out_ch.verdict;
        got.sequence_res  = out_ch.sequence_res;
        got.command_class = out_ch.command_class;
        got.body_length   = out_ch.body_length;
        sb.check_result(got);
      end
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input op_e op, input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.rx_byte   <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    if (sb.note_input(op, b)) begin
      counted_items++;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.apply_reg(idx, data);
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(CFG_HEADER_FIRST, {8'($urandom), c.header_first});
    write_reg(CFG_HEADER_SECOND, {8'($urandom), c.header_second});
    write_reg(CFG_MIN_LENGTH, {8'($urandom), c.min_length});
    write_reg(CFG_CRC_SEED, c.crc_seed);
    write_reg(CFG_ACCEPT_ZERO, {15'($urandom), c.accept_zero_crc});
    write_reg(CFG_COMMAND_COUNT, {8'($urandom), c.command_count});
    write_reg(CfgIdxSpareA, 16'($urandom));
    write_reg(CfgIdxSpareB, 16'($urandom));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // length byte and payload; a timeout replaces payload byte number cut
  task automatic send_payload(input logic [7:0] len, input logic [7:0] seq,
                              input logic [7:0] cls, input crc_mode_e mode, input int cut);
    logic [15:0] crc, sent;
    logic [7:0]  b;
    int          flen;
    flen = len;
    crc  = sb.cfg.crc_seed;
    sent = '0;
    send_item(OP_BYTE, len);
    for (int i = 0; i < flen; i++) begin
      if (i == cut) begin
        send_item(OP_TIMEOUT, 8'($urandom));
        return;
      end
      if (i == 0) begin
        b = seq;
      end else if (i == 1) begin
        b = cls;
      end else if (i < flen - 2) begin
        b = 8'($urandom);
      end else if (i == flen - 2) begin
        case (mode)
          CRC_GOOD: sent = crc;
          CRC_ZERO: sent = 16'h0000;
          default:  sent = crc ^ 16'($urandom_range(1, 65535));
        endcase
        b = sent[7:0];
      end else begin
        b = sent[15:8];
      end
      if (i < flen - 2) begin
        crc = frame_scoreboard::crc_update(crc, b);
      end
      send_item(OP_BYTE, b);
    end
  endtask

  // sync pair; the first byte is left out now and then when it is already latched
  task automatic send_header();
    if (sb.phase != PH_IDLE) begin
      send_item(OP_TIMEOUT, 8'($urandom));
    end
    if (sb.last_byte != sb.cfg.header_first ||
        (sb.cfg.header_first != sb.cfg.header_second && $urandom_range(1))) begin
      send_item(OP_BYTE, sb.cfg.header_first);
    end
    send_item(OP_BYTE, sb.cfg.header_second);
  endtask

  task automatic send_frame();
    logic [7:0] floor, len, seq, cls;
    int         pick, span;
    crc_mode_e  mode;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom));
    end
    send_header();
    floor = (sb.cfg.min_length < LenFloor) ? LenFloor : sb.cfg.min_length;
    pick  = $urandom_range(99);
    if (pick < 8) begin
      send_item(OP_BYTE, 8'($urandom_range(int'(floor) - 1)));
      repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom));
      send_item(OP_TIMEOUT, 8'($urandom));
      return;
    end
    span = 255 - int'(floor);
    if (pick >= 11 && span > 12) begin
      span = 12;
    end
    len = floor + 8'($urandom_range(span));
    seq = {($urandom_range(3) == 0), 7'($urandom)};
    if (sb.cfg.command_count != 0 && $urandom_range(1)) begin
      cls = 8'($urandom_range(int'(sb.cfg.command_count) - 1));
    end else begin
      cls = 8'($urandom);
    end
    pick = $urandom_range(99);
    mode = (pick < 70) ? CRC_GOOD : ((pick < 80) ? CRC_ZERO : CRC_BAD);
    send_payload(len, seq, cls, mode,
                 ($urandom_range(19) == 0) ? int'($urandom_range(int'(len) - 1)) : NoCut);
    if ($urandom_range(19) == 0) begin
      send_item(OP_TIMEOUT, 8'($urandom));
    end
  endtask

  function automatic cfg_t pick_config(int slot);
    cfg_t c;
    case (slot)
      0: c = '{header_first: 8'h00, header_second: 8'h00, min_length: 8'd2,
               crc_seed: 16'h0000, accept_zero_crc: 1'b0, command_count: 8'd0};
      1: c = '{header_first: 8'hFF, header_second: 8'hFF, min_length: 8'd255,
               crc_seed: 16'hFFFF, accept_zero_crc: 1'b1, command_count: 8'd255};
      default: begin
        c.header_first    = 8'($urandom);
        c.header_second   = 8'($urandom);
        c.min_length      = 8'd4 + 8'($urandom_range(8));
        c.crc_seed        = 16'($urandom);
        c.accept_zero_crc = 1'($urandom);
        c.command_count   = $urandom_range(1) ? 8'($urandom_range(1, 32)) : 8'($urandom);
      end
    endcase
    return c;
  endfunction

  initial begin : stimulus
    int sender_mix[4];
    int stall_mix[4];
    int slot_start;
    sender_mix = '{0, 69, 0, 25};
    stall_mix  = '{0, 0, 69, 25};
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_BYTE;
    in_ch.rx_byte   = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: idle timeout, ack frame, lone second sync with zero crc,
    // short length into error, timeout in mid payload
    send_item(OP_TIMEOUT, 8'hFF);
    send_item(OP_BYTE, 8'hAA);
    send_item(OP_BYTE, 8'h55);
    send_payload(8'd6, 8'hFF, 8'hFF, CRC_GOOD, NoCut);
    send_item(OP_BYTE, 8'h55);
    send_payload(8'd4, 8'h00, 8'h00, CRC_ZERO, NoCut);
    send_item(OP_BYTE, 8'hAA);
    send_item(OP_BYTE, 8'h55);
    send_item(OP_BYTE, 8'd3);
    send_item(OP_TIMEOUT, 8'h00);
    send_item(OP_BYTE, 8'h55);
    send_payload(8'd5, 8'h02, 8'h03, CRC_GOOD, 2);

    for (int slot = 0; slot < NumSlots; slot++) begin
      drain();
      sender_idle_pct = sender_mix[slot / 2];
      recv_stall_pct  = stall_mix[slot / 2];
      write_config(pick_config(slot));
      slot_start = counted_items;
      while (counted_items - slot_start < SlotItems) begin
        send_frame();
      end
      if (slot == 0) begin
        // long receiver hold-off while the sender keeps streaming
        hold_req <= 1'b1;
        send_header();
        send_payload(8'd40, 8'($urandom), 8'($urandom), CRC_GOOD, NoCut);
      end
    end

    drain();
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    end
    $display("Covered %0d items over %0d register settings and four traffic mixes.",
             counted_items, n_settings + 1);
    $display("Saw %0d body bytes, %0d timeouts, verdicts cmd/ack/unknown/crc %0d/%0d/%0d/%0d.",
             sb.n_body, sb.n_timeout, sb.n_verdict[0], sb.n_verdict[1], sb.n_verdict[2],
             sb.n_verdict[3]);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cfcr_pkg.sv
rtl/cfcr_if.sv
rtl/cfcr_cfg_regs.sv
rtl/cfcr_parser.sv
rtl/crc16_command_frame_receiver.sv
dv/crc16_command_frame_receiver_test.sv
